>>> rtl/msdeq_pkg.sv
`timescale 1ns / 1ps

package msdeq_pkg;

   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   typedef enum logic [1:0] {
      OP_POLL   = 2'd0,
      OP_NOTIFY = 2'd1,
      OP_POP    = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   typedef struct packed {
      logic              read_ok;
      logic              reading;
      logic [TIME_W-1:0] now_ms;
      op_type            op;
   } item_type;

   // one queued transition: level it went to and when
   typedef struct packed {
      logic              edge_level;
      logic [TIME_W-1:0] time_ms;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              edge_dropped;
      logic [TIME_W-1:0] pop_time_ms;
      logic              pop_edge;
      logic              pop_ok;
      logic              level_valid;
      logic              confirmed_mains;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

>>> rtl/mains_sense_debounce_event_queue_unit.sv
`timescale 1ns / 1ps

// Debounces a mains-present sense line and queues confirmed transitions. Each
// req beat carries an operation in tuser (poll, interrupt notify, pop, init) and
// gives exactly one rsp beat. A beat is registered at the input, runs through one
// pass of compare and update logic and lands in the output register, so one beat
// per cycle is sustained while rsp_tready stays high.
// The transition queue is a ring of QUEUE_DEPTH entries holding QUEUE_DEPTH - 1
// transitions; a confirmed edge that finds it full is dropped and flagged. The
// debounce time is written through csr_wr_en / csr_wr_data and should only change
// while no beats are in flight.
module mains_sense_debounce_event_queue_unit #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [39:0]                      req_tdata,   // now_ms, reading, read_ok
   input  logic [1:0]                       req_tuser,   // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // confirmed_mains, level_valid, pop_ok, pop_edge, pop_time_ms, edge_dropped
   output logic [39:0]                      rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [msdeq_pkg::DEBOUNCE_W-1:0] csr_wr_data
);

   logic                             in_valid_ff;
   msdeq_pkg::item_type              item_ff, item_in;
   logic                             out_valid_ff, out_valid_in;
   msdeq_pkg::result_type            result_ff;
   msdeq_pkg::result_type            result;
   logic [msdeq_pkg::DEBOUNCE_W-1:0] debounce_ff;
   logic                             advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign item_in.op      = msdeq_pkg::op_type'(req_tuser);
   assign item_in.now_ms  = req_tdata[31:0];
   assign item_in.reading = req_tdata[32];
   assign item_in.read_ok = req_tdata[33];

   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         debounce_ff  <= msdeq_pkg::DEBOUNCE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            debounce_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   msdeq_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (item_ff),
      .debounce_ms (debounce_ff),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(40 - msdeq_pkg::RESULT_W){1'b0}}, result_ff};

endmodule

>>> rtl/msdeq_ram.sv
`timescale 1ns / 1ps

module msdeq_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msdeq_core.sv
`timescale 1ns / 1ps

module msdeq_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  msdeq_pkg::item_type              item,
   input  logic [msdeq_pkg::DEBOUNCE_W-1:0] debounce_ms,
   output msdeq_pkg::result_type            result
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [msdeq_pkg::TIME_W-1:0] sample_after_ff, sample_after_in;
   logic                         previous_ff, previous_in;
   logic                         confirmed_ff, confirmed_in;
   logic                         valid_ff, valid_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic                         bypass_valid_ff, bypass_valid_in;
   msdeq_pkg::entry_type         bypass_entry_ff;

   logic                         gate_open;
   logic [msdeq_pkg::TIME_W-1:0] notify_sum;
   logic [PTR_W-1:0]             tail_next;
   logic [PTR_W-1:0]             head_next;
   logic                         ring_full;
   logic                         wr_en;
   msdeq_pkg::entry_type         wr_entry;
   msdeq_pkg::entry_type         ram_entry;
   msdeq_pkg::entry_type         head_entry;
   logic [msdeq_pkg::ENTRY_W-1:0] ram_rd_data;

   // read address follows the next head, so the registered read data holds the entry at head_ff
   msdeq_ram #(
      .WIDTH (msdeq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   assign ram_entry  = ram_rd_data;
   assign head_entry = bypass_valid_ff ? bypass_entry_ff : ram_entry;

   assign gate_open  = (sample_after_ff == '0) || (item.now_ms >= sample_after_ff);
   assign notify_sum = item.now_ms + {{(msdeq_pkg::TIME_W - msdeq_pkg::DEBOUNCE_W){1'b0}},
                                      debounce_ms};
   assign tail_next  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
   assign head_next  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign ring_full  = (tail_next == head_ff);

   assign wr_entry.edge_level = item.reading;
   assign wr_entry.time_ms    = item.now_ms;

   always_comb begin
      sample_after_in = sample_after_ff;
      previous_in     = previous_ff;
      confirmed_in    = confirmed_ff;
      valid_in        = valid_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      wr_en           = 1'b0;
      result          = '0;
      if (fire) begin
         unique case (item.op)
            msdeq_pkg::OP_POLL: begin
               if (gate_open && item.read_ok) begin
                  valid_in = 1'b1;
                  if (item.reading == previous_ff && item.reading != confirmed_ff) begin
                     confirmed_in = item.reading;
                     if (ring_full) begin
                        result.edge_dropped = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = tail_next;
                     end
                  end
                  previous_in = item.reading;
               end
            end
            msdeq_pkg::OP_NOTIFY: begin
               if (notify_sum > sample_after_ff) begin
                  sample_after_in = notify_sum;
               end
            end
            msdeq_pkg::OP_POP: begin
               if (head_ff != tail_ff) begin
                  result.pop_ok      = 1'b1;
                  result.pop_edge    = head_entry.edge_level;
                  result.pop_time_ms = head_entry.time_ms;
                  head_in            = head_next;
               end
            end
            msdeq_pkg::OP_INIT: begin
               sample_after_in = '0;
               head_in         = '0;
               tail_in         = '0;
               valid_in        = item.read_ok;
               previous_in     = item.read_ok & item.reading;
               confirmed_in    = item.read_ok & item.reading;
            end
         endcase
      end
      result.confirmed_mains = confirmed_in;
      result.level_valid     = valid_in;
   end

   // a write to the entry being read this cycle comes back stale from the ram
   assign bypass_valid_in = wr_en && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_after_ff <= '0;
         previous_ff     <= 1'b0;
         confirmed_ff    <= 1'b0;
         valid_ff        <= 1'b0;
         head_ff         <= '0;
         tail_ff         <= '0;
         bypass_valid_ff <= 1'b0;
      end else begin
         sample_after_ff <= sample_after_in;
         previous_ff     <= previous_in;
         confirmed_ff    <= confirmed_in;
         valid_ff        <= valid_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         bypass_valid_ff <= bypass_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_entry_ff <= wr_entry;
   end

`ifndef SYNTHESIS
   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == msdeq_pkg::OP_INIT |=> head_ff == tail_ff && sample_after_ff == '0)
      else $error("init left ring or gate set");

   a_drop_keeps_tail: assert property (@(posedge clock) disable iff (reset)
      fire && result.edge_dropped |=> tail_ff == $past(tail_ff))
      else $error("dropped edge moved the tail");

   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      fire && result.pop_ok |=> head_ff != $past(head_ff))
      else $error("pop did not advance the head");

   a_gate_rises: assert property (@(posedge clock) disable iff (reset)
      !(fire && item.op == msdeq_pkg::OP_INIT) |=> sample_after_ff >= $past(sample_after_ff))
      else $error("sample gate fell without init");

   a_confirmed_needs_valid: assert property (@(posedge clock) disable iff (reset)
      confirmed_ff |-> valid_ff)
      else $error("confirmed level set without a valid reading");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int RING_DEPTH  = 8;
   localparam int CYCLE_LIMIT = 150000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [39:0]                      req_tdata  = '0;   // now_ms, reading, read_ok
   logic [1:0]                       req_tuser  = '0;   // op
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // confirmed_mains, level_valid, pop_ok, pop_edge, pop_time_ms, edge_dropped
   logic [39:0]                      rsp_tdata;
   logic                             csr_wr_en   = 1'b0;
   logic [msdeq_pkg::DEBOUNCE_W-1:0] csr_wr_data = '0;

   mains_sense_debounce_event_queue_unit #(
      .QUEUE_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // predicted state of the debouncer
   logic [msdeq_pkg::DEBOUNCE_W-1:0] debounce_cfg = msdeq_pkg::DEBOUNCE_RESET;
   logic [msdeq_pkg::TIME_W-1:0]     gate_ms;
   logic                             last_level;
   logic                             stable_level;
   logic                             level_ok;
   msdeq_pkg::entry_type             edge_store [RING_DEPTH];
   int                               edge_head;
   int                               edge_tail;

   msdeq_pkg::item_type   sense_items_queue[$];
   msdeq_pkg::result_type awaited_status[$];
   int         queued_count   = 0;
   int         accepted_count = 0;
   int         fail_count     = 0;
   int         cycle_count    = 0;
   logic       req_taken      = 1'b0;

   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   logic       pressure_on    = 1'b0;
   int         hold_count     = 0;
   logic [msdeq_pkg::TIME_W-1:0] clock_ms = '0;

   msdeq_pkg::item_type   next_item;
   msdeq_pkg::item_type   seen_item;
   msdeq_pkg::result_type want;
   msdeq_pkg::result_type got;

   function automatic void clear_sense_state();
      gate_ms      = '0;
      last_level   = 1'b0;
      stable_level = 1'b0;
      level_ok     = 1'b0;
      edge_head    = 0;
      edge_tail    = 0;
   endfunction

   function automatic msdeq_pkg::result_type advance_sense_state(msdeq_pkg::item_type it);
      msdeq_pkg::result_type        r;
      logic [msdeq_pkg::TIME_W-1:0] gate_sum;
      int                           next_tail;
      r = '0;
      case (it.op)
         msdeq_pkg::OP_POLL: begin
            if ((gate_ms == '0 || it.now_ms >= gate_ms) && it.read_ok) begin
               level_ok = 1'b1;
               if (it.reading == last_level && it.reading != stable_level) begin
                  stable_level = it.reading;
                  next_tail = (edge_tail + 1) % RING_DEPTH;
                  if (next_tail == edge_head) begin
                     r.edge_dropped = 1'b1;
                  end else begin
                     edge_store[edge_tail].edge_level = it.reading;
                     edge_store[edge_tail].time_ms    = it.now_ms;
                     edge_tail = next_tail;
                  end
               end
               last_level = it.reading;
            end
         end
         msdeq_pkg::OP_NOTIFY: begin
            gate_sum = it.now_ms + {{(msdeq_pkg::TIME_W-msdeq_pkg::DEBOUNCE_W){1'b0}},
                                    debounce_cfg};
            if (gate_sum > gate_ms) gate_ms = gate_sum;
         end
         msdeq_pkg::OP_POP: begin
            if (edge_head != edge_tail) begin
               r.pop_ok      = 1'b1;
               r.pop_edge    = edge_store[edge_head].edge_level;
               r.pop_time_ms = edge_store[edge_head].time_ms;
               edge_head = (edge_head + 1) % RING_DEPTH;
            end
         end
         default: begin
            clear_sense_state();
            if (it.read_ok) begin
               level_ok     = 1'b1;
               last_level   = it.reading;
               stable_level = it.reading;
            end
         end
      endcase
      r.confirmed_mains = stable_level;
      r.level_valid     = level_ok;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (sense_items_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = sense_items_queue.pop_front();
            req_tdata  <= {6'b0, next_item.read_ok, next_item.reading, next_item.now_ms};
            req_tuser  <= next_item.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: random stalls, or a long hold-off window under pressure
   always @(negedge clock) begin
      if (pressure_on) begin
         hold_count <= (hold_count == 99) ? 0 : hold_count + 1;
         rsp_tready <= (hold_count >= 70);
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predicts on every accepted req beat, checks every rsp beat
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout", $time);
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            seen_item.op      = msdeq_pkg::op_type'(req_tuser);
            seen_item.now_ms  = req_tdata[31:0];
            seen_item.reading = req_tdata[32];
            seen_item.read_ok = req_tdata[33];
            awaited_status.push_back(advance_sense_state(seen_item));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[msdeq_pkg::RESULT_W-1:0];
            if (awaited_status.size() == 0) begin
               $display("%0t ns: beat with nothing expected, expected none, got %0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = awaited_status.pop_front();
               check_field("confirmed_mains", 32'(want.confirmed_mains),
                           32'(got.confirmed_mains));
               check_field("level_valid", 32'(want.level_valid), 32'(got.level_valid));
               check_field("pop_ok", 32'(want.pop_ok), 32'(got.pop_ok));
               check_field("pop_edge", 32'(want.pop_edge), 32'(got.pop_edge));
               check_field("pop_time_ms", want.pop_time_ms, got.pop_time_ms);
               check_field("edge_dropped", 32'(want.edge_dropped), 32'(got.edge_dropped));
            end
         end
      end
   end

   task automatic queue_item(msdeq_pkg::op_type op, logic [msdeq_pkg::TIME_W-1:0] t,
                             logic rd, logic ok);
      msdeq_pkg::item_type it;
      it.op      = op;
      it.now_ms  = t;
      it.reading = rd;
      it.read_ok = ok;
      sense_items_queue.push_back(it);
      queued_count++;
   endtask

   task automatic write_debounce(logic [msdeq_pkg::DEBOUNCE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      debounce_cfg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || awaited_status.size() != 0)
         @(negedge clock);
   endtask

   // mostly matching poll pairs so edges get confirmed, mixed with notify, pop, init
   task automatic queue_random_items(int count);
      int   pick;
      logic rd;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(19) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(30);
         pick = $urandom_range(99);
         rd   = 1'($urandom_range(1));
         if (pick < 40) begin
            queue_item(msdeq_pkg::OP_POLL, clock_ms, rd, $urandom_range(9) != 0);
            queue_item(msdeq_pkg::OP_POLL, clock_ms + $urandom_range(5), rd,
                       $urandom_range(9) != 0);
            n++;
         end else if (pick < 55) begin
            queue_item(msdeq_pkg::OP_POLL, clock_ms, rd, 1'($urandom_range(1)));
         end else if (pick < 67) begin
            queue_item(msdeq_pkg::OP_NOTIFY, clock_ms, rd, 1'($urandom_range(1)));
         end else if (pick < 95) begin
            queue_item(msdeq_pkg::OP_POP, $urandom, rd, 1'($urandom_range(1)));
         end else begin
            queue_item(msdeq_pkg::OP_INIT, $urandom, rd, $urandom_range(3) != 0);
         end
      end
   endtask

   initial begin
      clear_sense_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset debounce time, no idling
      queue_item(msdeq_pkg::OP_POP, 32'd0, 1'b0, 1'b1);            // pop from empty ring
      queue_item(msdeq_pkg::OP_POLL, 32'd5, 1'b1, 1'b0);           // failed read
      queue_item(msdeq_pkg::OP_INIT, 32'd0, 1'b1, 1'b0);           // init with failed read
      queue_item(msdeq_pkg::OP_INIT, 32'd0, 1'b1, 1'b1);
      queue_item(msdeq_pkg::OP_POLL, 32'd100, 1'b0, 1'b1);
      queue_item(msdeq_pkg::OP_POLL, 32'd101, 1'b0, 1'b1);         // confirms mains lost
      queue_item(msdeq_pkg::OP_NOTIFY, 32'd200, 1'b0, 1'b1);
      queue_item(msdeq_pkg::OP_POLL, 32'd210, 1'b1, 1'b1);         // still gated
      queue_item(msdeq_pkg::OP_POLL, 32'd220, 1'b1, 1'b1);         // gate just reached
      queue_item(msdeq_pkg::OP_POLL, 32'd221, 1'b1, 1'b1);
      queue_item(msdeq_pkg::OP_NOTIFY, 32'hFFFF_FFF0, 1'b0, 1'b1); // sum wraps low, gate keeps
      queue_item(msdeq_pkg::OP_NOTIFY, 32'hFFFF_FF00, 1'b0, 1'b1);
      queue_item(msdeq_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_item(msdeq_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0);   // failed read on open gate
      queue_item(msdeq_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b1);
      // fill the ring until one edge is dropped
      for (int k = 0; k < 5; k++) begin
         queue_item(msdeq_pkg::OP_POLL, 32'hFFFF_FFFF, !k[0], 1'b1);
         queue_item(msdeq_pkg::OP_POLL, 32'hFFFF_FFFF, !k[0], 1'b1);
      end
      queue_item(msdeq_pkg::OP_POP, 32'd0, 1'b0, 1'b0);
      queue_item(msdeq_pkg::OP_INIT, 32'd0, 1'b0, 1'b1);
      queue_item(msdeq_pkg::OP_POP, 32'd0, 1'b0, 1'b0);            // init emptied the ring
      wait_drained();

      write_debounce('0);
      queue_random_items(100);
      wait_drained();

      write_debounce(16'hFFFF);
      send_idle_pct = 71;
      queue_random_items(100);
      wait_drained();

      write_debounce(16'($urandom_range(65535)));
      send_idle_pct  = 0;
      recv_stall_pct = 71;
      queue_random_items(100);
      wait_drained();

      write_debounce(16'd1);
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      queue_random_items(100);
      wait_drained();

      write_debounce(16'($urandom_range(200)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_on    = 1'b1;
      queue_random_items(150);
      wait_drained();

      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/msdeq_pkg.sv
rtl/msdeq_ram.sv
rtl/msdeq_core.sv
rtl/mains_sense_debounce_event_queue_unit.sv
tb/sv/tb_top.sv
